// File: sv/phkl_pkg.sv
package phkl_pkg;

    localparam int MAX_KEY_LEN_DEF  = 32;
    localparam int SYMBOL_SET_DEF   = 256;
    localparam int MAX_VERTICES_DEF = 4096;

    localparam int WEIGHT_W     = 16;
    localparam int KEY_LEN_W    = 6;
    localparam int SYMBOL_W     = 8;
    localparam int SET_SIZE_W   = 9;
    localparam int VCOUNT_W     = 13;
    localparam int ECOUNT_W     = 15;
    localparam int TADDR_W      = 13;
    localparam int CFG_IDX_W    = 3;
    localparam int CFG_DATA_W   = 15;
    localparam int DIVIDEND_W   = 17;
    localparam int DIVISOR_W    = 15;

    localparam logic [CFG_IDX_W-1:0] CFG_KEY_LENGTH   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SYMBOL_MIN   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SET_SIZE     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_VERTEX_COUNT = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_ENTRY_COUNT  = 3'd4;

    typedef enum logic [1:0] {
        ACT_HASH   = 2'd0,
        ACT_FIRST  = 2'd1,
        ACT_SECOND = 2'd2,
        ACT_VERTEX = 2'd3
    } action_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ADD,
        ST_MOD_UV,
        ST_RD_U,
        ST_RD_V,
        ST_SUM,
        ST_MOD_E,
        ST_RESULT
    } state_t;

    typedef struct packed {
        logic                 start;
        logic [DIVIDEND_W-1:0] dividend_a;
        logic [DIVIDEND_W-1:0] dividend_b;
        logic [DIVISOR_W-1:0]  divisor;
    } mod_req_t;

    typedef struct packed {
        logic                 done;
        logic [DIVISOR_W-1:0] rem_a;
        logic [DIVISOR_W-1:0] rem_b;
    } mod_rsp_t;

endpackage

// File: sv/phkl_ram.sv
module phkl_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256,
    localparam int AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             wr_en,
    input  logic [AddrW-1:0] wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic [AddrW-1:0] rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// File: sv/phkl_mod.sv
module phkl_mod (
    input  logic               aclk,
    input  logic               aresetn,
    input  phkl_pkg::mod_req_t req,
    output phkl_pkg::mod_rsp_t rsp
);

    localparam int DvdW = phkl_pkg::DIVIDEND_W;
    localparam int DivW = phkl_pkg::DIVISOR_W;
    localparam int CntW = $clog2(DvdW);

    logic [DvdW-1:0] dvd_a_reg, dvd_a_next;
    logic [DvdW-1:0] dvd_b_reg, dvd_b_next;
    logic [DivW-1:0] div_reg, div_next;
    logic [DivW-1:0] rem_a_reg, rem_a_next;
    logic [DivW-1:0] rem_b_reg, rem_b_next;
    logic [CntW-1:0] cnt_reg, cnt_next;
    logic            busy_reg, busy_next;
    logic            done_reg, done_next;

    function automatic logic [DivW-1:0] rem_step(input logic [DivW-1:0] rem,
                                                 input logic in_bit,
                                                 input logic [DivW-1:0] d);
        logic [DivW:0] trial;
        trial = {rem, in_bit};
        if (trial >= {1'b0, d}) begin
            trial = trial - {1'b0, d};
        end
        return trial[DivW-1:0];
    endfunction

    always_comb begin
        dvd_a_next = dvd_a_reg;
        dvd_b_next = dvd_b_reg;
        div_next   = div_reg;
        rem_a_next = rem_a_reg;
        rem_b_next = rem_b_reg;
        cnt_next   = cnt_reg;
        busy_next  = busy_reg;
        done_next  = 1'b0;
        if (req.start) begin
            dvd_a_next = req.dividend_a;
            dvd_b_next = req.dividend_b;
            div_next   = req.divisor;
            rem_a_next = '0;
            rem_b_next = '0;
            cnt_next   = '0;
            busy_next  = 1'b1;
        end else if (busy_reg) begin
            rem_a_next = rem_step(rem_a_reg, dvd_a_reg[DvdW-1], div_reg);
            rem_b_next = rem_step(rem_b_reg, dvd_b_reg[DvdW-1], div_reg);
            dvd_a_next = {dvd_a_reg[DvdW-2:0], 1'b0};
            dvd_b_next = {dvd_b_reg[DvdW-2:0], 1'b0};
            cnt_next   = cnt_reg + 1'b1;
            if (cnt_reg == CntW'(DvdW - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        dvd_a_reg <= dvd_a_next;
        dvd_b_reg <= dvd_b_next;
        div_reg   <= div_next;
        rem_a_reg <= rem_a_next;
        rem_b_reg <= rem_b_next;
    end

    assign rsp.done  = done_reg;
    assign rsp.rem_a = rem_a_reg;
    assign rsp.rem_b = rem_b_reg;

endmodule

// File: sv/perfect_hash_key_lookup_core.sv
// channel  | handshake         | payload
// s_       | s_valid / s_ready | s_action, s_symbol, s_table_address, s_table_value
// m_       | m_valid / m_ready | m_hash_index, m_bad_symbol
// cfg_     | cfg_wr_en         | cfg_index, cfg_data
// Load word: written straight into its table. Hash byte: weight RAM read, then add.
// Last byte of a key: passes through the bit-serial remainder unit
// (17 steps for both vertex remainders, 17 for the final one) and two g reads.
// The finished result sits in an output register; new words are taken while it waits.
// Reset: synchronous active-low aresetn; tables are not cleared.
module perfect_hash_key_lookup_core #(
    parameter int MAX_KEY_LEN  = phkl_pkg::MAX_KEY_LEN_DEF,
    parameter int SYMBOL_SET   = phkl_pkg::SYMBOL_SET_DEF,
    parameter int MAX_VERTICES = phkl_pkg::MAX_VERTICES_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_wr_en,
    input  logic [phkl_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [phkl_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [1:0]                          s_action,
    input  logic [phkl_pkg::SYMBOL_W-1:0]       s_symbol,
    input  logic [phkl_pkg::TADDR_W-1:0]        s_table_address,
    input  logic [phkl_pkg::WEIGHT_W-1:0]       s_table_value,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [phkl_pkg::ECOUNT_W-1:0]       m_hash_index,
    output logic                                m_bad_symbol
);

    localparam int WeightDepth = MAX_KEY_LEN * SYMBOL_SET;
    localparam int WaddrW = (WeightDepth > 1) ? $clog2(WeightDepth) : 1;
    localparam int VaddrW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
    localparam int PosW   = (MAX_KEY_LEN > 1) ? $clog2(MAX_KEY_LEN) : 1;
    localparam int WW     = phkl_pkg::WEIGHT_W;
    localparam int DivW   = phkl_pkg::DIVISOR_W;
    localparam int DvdW   = phkl_pkg::DIVIDEND_W;

    phkl_pkg::state_t state_reg, state_next;

    logic [phkl_pkg::KEY_LEN_W-1:0]  key_length_reg;
    logic [phkl_pkg::SYMBOL_W-1:0]   symbol_min_reg;
    logic [phkl_pkg::SET_SIZE_W-1:0] set_size_reg;
    logic [phkl_pkg::VCOUNT_W-1:0]   vertex_count_reg;
    logic [phkl_pkg::ECOUNT_W-1:0]   entry_count_reg;

    logic [WW-1:0]   sum1_reg, sum1_next;
    logic [WW-1:0]   sum2_reg, sum2_next;
    logic [PosW-1:0] pos_reg, pos_next;
    logic            err_reg, err_next;
    logic            err_key_reg, err_key_next;
    logic            ok_reg, ok_next;
    logic            last_reg, last_next;
    logic [WW-1:0]   gu_reg, gu_next;
    logic            m_valid_reg, m_valid_next;
    logic [phkl_pkg::ECOUNT_W-1:0] hash_reg, hash_next;
    logic            bad_reg, bad_next;

    logic accept;
    logic hash_acc;
    phkl_pkg::action_t act;

    logic [31:0] len_eff;
    logic [31:0] vc_eff;
    logic [DivW-1:0] vc_div;
    logic [DivW-1:0] ec_div;
    logic [phkl_pkg::SYMBOL_W-1:0] offset;
    logic        sym_ok;
    logic [31:0] idx_wide;
    logic [31:0] taddr_wide;
    logic [31:0] rem_u_wide;
    logic [31:0] rem_v_wide;
    logic [WW-1:0] add1;
    logic [WW-1:0] add2;
    logic [DvdW-1:0] g_total;

    logic              w1_we, w2_we, g_we;
    logic [WaddrW-1:0] w_waddr, w_raddr;
    logic [VaddrW-1:0] g_waddr, g_raddr;
    logic [WW-1:0]     w1_rdata, w2_rdata, g_rdata;

    phkl_pkg::mod_req_t mod_req;
    phkl_pkg::mod_rsp_t mod_rsp;

    assign act      = phkl_pkg::action_t'(s_action);
    assign s_ready  = (state_reg == phkl_pkg::ST_IDLE);
    assign accept   = s_valid && s_ready;
    assign hash_acc = accept && (act == phkl_pkg::ACT_HASH);

    // config
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            key_length_reg   <= phkl_pkg::KEY_LEN_W'(1);
            symbol_min_reg   <= '0;
            set_size_reg     <= phkl_pkg::SET_SIZE_W'(256);
            vertex_count_reg <= phkl_pkg::VCOUNT_W'(1);
            entry_count_reg  <= phkl_pkg::ECOUNT_W'(1);
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                phkl_pkg::CFG_KEY_LENGTH: begin
                    key_length_reg <= cfg_data[phkl_pkg::KEY_LEN_W-1:0];
                end
                phkl_pkg::CFG_SYMBOL_MIN: begin
                    symbol_min_reg <= cfg_data[phkl_pkg::SYMBOL_W-1:0];
                end
                phkl_pkg::CFG_SET_SIZE: begin
                    set_size_reg <= cfg_data[phkl_pkg::SET_SIZE_W-1:0];
                end
                phkl_pkg::CFG_VERTEX_COUNT: begin
                    vertex_count_reg <= cfg_data[phkl_pkg::VCOUNT_W-1:0];
                end
                phkl_pkg::CFG_ENTRY_COUNT: begin
                    entry_count_reg <= cfg_data[phkl_pkg::ECOUNT_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        if (key_length_reg == '0) begin
            len_eff = 32'd1;
        end else if (32'(key_length_reg) > 32'(MAX_KEY_LEN)) begin
            len_eff = 32'(MAX_KEY_LEN);
        end else begin
            len_eff = 32'(key_length_reg);
        end
        if (vertex_count_reg == '0) begin
            vc_eff = 32'd1;
        end else if (32'(vertex_count_reg) > 32'(MAX_VERTICES)) begin
            vc_eff = 32'(MAX_VERTICES);
        end else begin
            vc_eff = 32'(vertex_count_reg);
        end
        vc_div = vc_eff[DivW-1:0];
        ec_div = (entry_count_reg == '0) ? DivW'(1) : entry_count_reg;
    end

    // symbol check and weight address
    assign offset   = s_symbol - symbol_min_reg;
    assign sym_ok   = (s_symbol >= symbol_min_reg)
                   && ({1'b0, offset} < set_size_reg)
                   && (32'(offset) < 32'(SYMBOL_SET))
                   && (32'(pos_reg) < 32'(MAX_KEY_LEN));
    assign idx_wide = 32'(pos_reg) * 32'(SYMBOL_SET) + 32'(offset);
    assign taddr_wide = 32'(s_table_address);

    assign w_raddr = idx_wide[WaddrW-1:0];
    assign w_waddr = taddr_wide[WaddrW-1:0];
    assign w1_we   = accept && (act == phkl_pkg::ACT_FIRST)
                  && (taddr_wide < 32'(WeightDepth));
    assign w2_we   = accept && (act == phkl_pkg::ACT_SECOND)
                  && (taddr_wide < 32'(WeightDepth));
    assign g_we    = accept && (act == phkl_pkg::ACT_VERTEX)
                  && (taddr_wide < 32'(MAX_VERTICES));
    assign g_waddr = taddr_wide[VaddrW-1:0];

    assign rem_u_wide = 32'(mod_rsp.rem_a);
    assign rem_v_wide = 32'(mod_rsp.rem_b);
    assign g_raddr = (state_reg == phkl_pkg::ST_RD_U) ? rem_u_wide[VaddrW-1:0]
                                                      : rem_v_wide[VaddrW-1:0];

    phkl_ram #(.WIDTH(WW), .DEPTH(WeightDepth)) u_first_weights (
        .aclk    (aclk),
        .wr_en   (w1_we),
        .wr_addr (w_waddr),
        .wr_data (s_table_value),
        .rd_addr (w_raddr),
        .rd_data (w1_rdata)
    );

    phkl_ram #(.WIDTH(WW), .DEPTH(WeightDepth)) u_second_weights (
        .aclk    (aclk),
        .wr_en   (w2_we),
        .wr_addr (w_waddr),
        .wr_data (s_table_value),
        .rd_addr (w_raddr),
        .rd_data (w2_rdata)
    );

    phkl_ram #(.WIDTH(WW), .DEPTH(MAX_VERTICES)) u_vertex_values (
        .aclk    (aclk),
        .wr_en   (g_we),
        .wr_addr (g_waddr),
        .wr_data (s_table_value),
        .rd_addr (g_raddr),
        .rd_data (g_rdata)
    );

    phkl_mod u_mod (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (mod_req),
        .rsp     (mod_rsp)
    );

    assign add1    = sum1_reg + w1_rdata;
    assign add2    = sum2_reg + w2_rdata;
    assign g_total = DvdW'(gu_reg) + DvdW'(g_rdata);

    always_comb begin
        state_next   = state_reg;
        sum1_next    = sum1_reg;
        sum2_next    = sum2_reg;
        pos_next     = pos_reg;
        err_next     = err_reg;
        err_key_next = err_key_reg;
        ok_next      = ok_reg;
        last_next    = last_reg;
        gu_next      = gu_reg;
        hash_next    = hash_reg;
        bad_next     = bad_reg;
        m_valid_next = m_valid_reg && !m_ready;
        mod_req      = '0;

        unique case (state_reg)
            phkl_pkg::ST_IDLE: begin
                if (hash_acc) begin
                    ok_next    = sym_ok;
                    last_next  = (32'(pos_reg) + 32'd1 >= len_eff);
                    state_next = phkl_pkg::ST_ADD;
                end
            end
            phkl_pkg::ST_ADD: begin
                if (ok_reg) begin
                    sum1_next = add1;
                    sum2_next = add2;
                end else begin
                    err_next = 1'b1;
                end
                pos_next = pos_reg + 1'b1;
                if (last_reg) begin
                    mod_req.start      = 1'b1;
                    mod_req.dividend_a = DvdW'(sum1_next);
                    mod_req.dividend_b = DvdW'(sum2_next);
                    mod_req.divisor    = vc_div;
                    err_key_next       = err_next;
                    sum1_next          = '0;
                    sum2_next          = '0;
                    pos_next           = '0;
                    err_next           = 1'b0;
                    state_next         = phkl_pkg::ST_MOD_UV;
                end else begin
                    state_next = phkl_pkg::ST_IDLE;
                end
            end
            phkl_pkg::ST_MOD_UV: begin
                if (mod_rsp.done) begin
                    state_next = phkl_pkg::ST_RD_U;
                end
            end
            phkl_pkg::ST_RD_U: begin
                state_next = phkl_pkg::ST_RD_V;
            end
            phkl_pkg::ST_RD_V: begin
                gu_next    = g_rdata;
                state_next = phkl_pkg::ST_SUM;
            end
            phkl_pkg::ST_SUM: begin
                mod_req.start      = 1'b1;
                mod_req.dividend_a = g_total;
                mod_req.divisor    = ec_div;
                state_next         = phkl_pkg::ST_MOD_E;
            end
            phkl_pkg::ST_MOD_E: begin
                if (mod_rsp.done) begin
                    state_next = phkl_pkg::ST_RESULT;
                end
            end
            phkl_pkg::ST_RESULT: begin
                if (!m_valid_reg || m_ready) begin
                    hash_next    = mod_rsp.rem_a;
                    bad_next     = err_key_reg;
                    m_valid_next = 1'b1;
                    state_next   = phkl_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = phkl_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= phkl_pkg::ST_IDLE;
            sum1_reg    <= '0;
            sum2_reg    <= '0;
            pos_reg     <= '0;
            err_reg     <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            sum1_reg    <= sum1_next;
            sum2_reg    <= sum2_next;
            pos_reg     <= pos_next;
            err_reg     <= err_next;
            m_valid_reg <= m_valid_next;
        end
        err_key_reg <= err_key_next;
        ok_reg      <= ok_next;
        last_reg    <= last_next;
        gu_reg      <= gu_next;
        hash_reg    <= hash_next;
        bad_reg     <= bad_next;
    end

    assign m_valid      = m_valid_reg;
    assign m_hash_index = hash_reg;
    assign m_bad_symbol = bad_reg;

endmodule

// File: sv/phkl_checker.sv
module phkl_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_valid,
    input logic                          s_ready,
    input logic [1:0]                    s_action,
    input logic                          m_valid,
    input logic                          m_ready,
    input logic [phkl_pkg::ECOUNT_W-1:0] m_hash_index,
    input logic                          m_bad_symbol
);

    // stalled result word holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_hash_index) && $stable(m_bad_symbol))
        else $error("result word changed while stalled");

    // index stays below the largest entry count
    a_index_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_hash_index != {phkl_pkg::ECOUNT_W{1'b1}})
        else $error("hash index out of range");

    // a hash byte makes the core drop s_ready
    a_hash_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && (s_action == phkl_pkg::ACT_HASH) |=> !s_ready)
        else $error("ready right after hash byte");

    // table loads leave the core ready
    a_load_fast: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && (s_action != phkl_pkg::ACT_HASH) |=> s_ready)
        else $error("not ready after table load");

endmodule

bind perfect_hash_key_lookup_core phkl_checker u_phkl_checker (.*);

// File: verif/perfect_hash_key_lookup_core_test.sv
module perfect_hash_key_lookup_core_test;
    import phkl_pkg::*;

    localparam int WEIGHT_DEPTH  = MAX_KEY_LEN_DEF * SYMBOL_SET_DEF;
    localparam int CYCLE_LIMIT   = 1000000;
    localparam int SETTLE_CYCLES = 64;
    localparam int RANDOM_PHASES = 9;
    localparam int PHASE_BUDGET  = 190;

    typedef struct packed {
        action_t               act;
        logic [SYMBOL_W-1:0]   sym;
        logic [TADDR_W-1:0]    addr;
        logic [WEIGHT_W-1:0]   value;
    } word_t;

    typedef struct packed {
        logic [ECOUNT_W-1:0] index;
        logic                bad;
    } lookup_t;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic                  s_valid = 1'b0;
    logic                  s_ready;
    logic [1:0]            s_action = '0;
    logic [SYMBOL_W-1:0]   s_symbol = '0;
    logic [TADDR_W-1:0]    s_table_address = '0;
    logic [WEIGHT_W-1:0]   s_table_value = '0;
    logic                  m_valid;
    logic                  m_ready = 1'b0;
    logic [ECOUNT_W-1:0]   m_hash_index;
    logic                  m_bad_symbol;

    perfect_hash_key_lookup_core uut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_action        (s_action),
        .s_symbol        (s_symbol),
        .s_table_address (s_table_address),
        .s_table_value   (s_table_value),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_hash_index    (m_hash_index),
        .m_bad_symbol    (m_bad_symbol)
    );

    always #1 aclk = ~aclk;

    word_t   input_words [$];
    lookup_t expected_lookups [$];
    word_t   cur_word;
    lookup_t want_lookup;
    int      send_idle_pct = 21;
    int      recv_idle_pct = 76;
    int      mismatch_count = 0;
    int      cycle_count = 0;
    int      phase_words = 0;

    // hash engine copy: registers, tables, partial key
    logic [KEY_LEN_W-1:0]  reg_key_length = KEY_LEN_W'(1);
    logic [SYMBOL_W-1:0]   reg_symbol_min = '0;
    logic [SET_SIZE_W-1:0] reg_set_size = SET_SIZE_W'(256);
    logic [VCOUNT_W-1:0]   reg_vertex_count = VCOUNT_W'(1);
    logic [ECOUNT_W-1:0]   reg_entry_count = ECOUNT_W'(1);
    logic [WEIGHT_W-1:0]   w1_table [WEIGHT_DEPTH];
    logic [WEIGHT_W-1:0]   w2_table [WEIGHT_DEPTH];
    logic [WEIGHT_W-1:0]   g_table [MAX_VERTICES_DEF];
    logic [WEIGHT_W-1:0]   sum_u = '0;
    logic [WEIGHT_W-1:0]   sum_v = '0;
    int                    key_pos = 0;
    logic                  key_bad = 1'b0;

    // stimulus planning: which entries hold data, so no unwritten entry is read
    bit [WEIGHT_W-1:0] plan_w1 [WEIGHT_DEPTH];
    bit [WEIGHT_W-1:0] plan_w2 [WEIGHT_DEPTH];
    bit                plan_w1_set [WEIGHT_DEPTH];
    bit                plan_w2_set [WEIGHT_DEPTH];
    bit                plan_g_set [MAX_VERTICES_DEF];
    bit [WEIGHT_W-1:0] plan_u = '0;
    bit [WEIGHT_W-1:0] plan_v = '0;
    int                plan_pos = 0;

    function automatic int key_bytes();
        if (reg_key_length == 0) return 1;
        if (reg_key_length > MAX_KEY_LEN_DEF) return MAX_KEY_LEN_DEF;
        return int'(reg_key_length);
    endfunction

    function automatic int vertex_mod();
        if (reg_vertex_count == 0) return 1;
        if (reg_vertex_count > MAX_VERTICES_DEF) return MAX_VERTICES_DEF;
        return int'(reg_vertex_count);
    endfunction

    function automatic int entry_mod();
        return (reg_entry_count == 0) ? 1 : int'(reg_entry_count);
    endfunction

    function automatic bit symbol_slot(input logic [SYMBOL_W-1:0] sym, output int slot);
        slot = int'(sym) - int'(reg_symbol_min);
        return sym >= reg_symbol_min && slot < int'(reg_set_size) && slot < SYMBOL_SET_DEF;
    endfunction

    function automatic void absorb_word(input word_t w);
        int      slot;
        int      idx;
        bit      ok;
        lookup_t res;
        case (w.act)
            ACT_FIRST:  w1_table[w.addr] = w.value;
            ACT_SECOND: w2_table[w.addr] = w.value;
            ACT_VERTEX: if (w.addr < MAX_VERTICES_DEF) g_table[w.addr] = w.value;
            ACT_HASH: begin
                ok = symbol_slot(w.sym, slot);
                if (ok) begin
                    idx = key_pos * SYMBOL_SET_DEF + slot;
                    sum_u = sum_u + w1_table[idx];
                    sum_v = sum_v + w2_table[idx];
                end else begin
                    key_bad = 1'b1;
                end
                key_pos++;
                if (key_pos >= key_bytes()) begin
                    res.index = ECOUNT_W'((int'(g_table[int'(sum_u) % vertex_mod()])
                        + int'(g_table[int'(sum_v) % vertex_mod()])) % entry_mod());
                    res.bad = key_bad;
                    expected_lookups.push_back(res);
                    sum_u = '0;
                    sum_v = '0;
                    key_pos = 0;
                    key_bad = 1'b0;
                end
            end
            default: ;
        endcase
    endfunction

    task automatic report_mismatch(input string field, input int got, input int want);
        $display("mismatch on %s at cycle %0d: got %0d, want %0d", field, cycle_count, got, want);
        mismatch_count++;
    endtask

    function automatic logic [WEIGHT_W-1:0] pick_value();
        case ($urandom_range(0, 5))
            0: return '0;
            1: return '1;
            default: return WEIGHT_W'($urandom);
        endcase
    endfunction

    function automatic logic [SYMBOL_W-1:0] pick_symbol();
        int top;
        int lo;
        lo = int'(reg_symbol_min);
        top = lo + int'(reg_set_size) - 1;
        if (top > 255) top = 255;
        if (reg_set_size == 0 || $urandom_range(0, 99) < 12) return SYMBOL_W'($urandom);
        if ($urandom_range(0, 1) == 1 && top > lo + 3) top = lo + 3;
        return SYMBOL_W'($urandom_range(top, lo));
    endfunction

    task automatic queue_load(input action_t act, input int addr, input logic [WEIGHT_W-1:0] value);
        word_t w;
        w.act = act;
        w.sym = SYMBOL_W'($urandom);
        w.addr = TADDR_W'(addr);
        w.value = value;
        input_words.push_back(w);
        phase_words++;
        case (act)
            ACT_FIRST: begin
                plan_w1[w.addr] = value;
                plan_w1_set[w.addr] = 1'b1;
            end
            ACT_SECOND: begin
                plan_w2[w.addr] = value;
                plan_w2_set[w.addr] = 1'b1;
            end
            ACT_VERTEX: if (w.addr < MAX_VERTICES_DEF) plan_g_set[w.addr] = 1'b1;
            default: ;
        endcase
    endtask

    task automatic queue_byte(input logic [SYMBOL_W-1:0] sym);
        word_t w;
        int    slot;
        int    idx;
        int    nv;
        bit    ok;
        ok = symbol_slot(sym, slot);
        if (ok) begin
            idx = plan_pos * SYMBOL_SET_DEF + slot;
            if (!plan_w1_set[idx]) queue_load(ACT_FIRST, idx, pick_value());
            if (!plan_w2_set[idx]) queue_load(ACT_SECOND, idx, pick_value());
            plan_u = plan_u + plan_w1[idx];
            plan_v = plan_v + plan_w2[idx];
        end
        plan_pos++;
        if (plan_pos >= key_bytes()) begin
            nv = vertex_mod();
            if (!plan_g_set[int'(plan_u) % nv]) queue_load(ACT_VERTEX, int'(plan_u) % nv, pick_value());
            if (!plan_g_set[int'(plan_v) % nv]) queue_load(ACT_VERTEX, int'(plan_v) % nv, pick_value());
            plan_u = '0;
            plan_v = '0;
            plan_pos = 0;
        end
        w.act = ACT_HASH;
        w.sym = sym;
        w.addr = TADDR_W'($urandom);
        w.value = WEIGHT_W'($urandom);
        input_words.push_back(w);
        phase_words++;
    endtask

    task automatic queue_key();
        action_t act;
        for (int n = 0; n < key_bytes(); n++) begin
            if ($urandom_range(0, 9) == 0) begin
                act = action_t'($urandom_range(int'(ACT_FIRST), int'(ACT_VERTEX)));
                queue_load(act, $urandom_range(0, 8191), pick_value());
            end
            queue_byte(pick_symbol());
        end
    endtask

    task automatic set_reg(input logic [CFG_IDX_W-1:0] idx, input int value, input int width);
        logic [CFG_DATA_W-1:0] data;
        data = CFG_DATA_W'(value);
        // junk above the register width must be dropped
        if ($urandom_range(0, 1) == 1) data = data | CFG_DATA_W'($urandom << width);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        case (idx)
            CFG_KEY_LENGTH:   reg_key_length = data[KEY_LEN_W-1:0];
            CFG_SYMBOL_MIN:   reg_symbol_min = data[SYMBOL_W-1:0];
            CFG_SET_SIZE:     reg_set_size = data[SET_SIZE_W-1:0];
            CFG_VERTEX_COUNT: reg_vertex_count = data[VCOUNT_W-1:0];
            CFG_ENTRY_COUNT:  reg_entry_count = data[ECOUNT_W-1:0];
            default: ;
        endcase
    endtask

    task automatic program_regs(input int kl, input int smin, input int ss, input int vc,
                                input int ec);
        set_reg(CFG_KEY_LENGTH, kl, KEY_LEN_W);
        set_reg(CFG_SYMBOL_MIN, smin, SYMBOL_W);
        set_reg(CFG_SET_SIZE, ss, SET_SIZE_W);
        set_reg(CFG_VERTEX_COUNT, vc, VCOUNT_W);
        set_reg(CFG_ENTRY_COUNT, ec, ECOUNT_W);
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        @(negedge aclk);
    endtask

    task automatic settle();
        do @(negedge aclk);
        while (input_words.size() != 0 || s_valid || expected_lookups.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) absorb_word(cur_word);
            if (!s_valid || s_ready) begin
                if (input_words.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                    cur_word = input_words.pop_front();
                    s_valid <= 1'b1;
                    s_action <= cur_word.act;
                    s_symbol <= cur_word.sym;
                    s_table_address <= cur_word.addr;
                    s_table_value <= cur_word.value;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (expected_lookups.size() == 0) begin
                    report_mismatch("unexpected result", int'(m_hash_index), -1);
                end else begin
                    want_lookup = expected_lookups.pop_front();
                    if (m_hash_index !== want_lookup.index)
                        report_mismatch("hash_index", int'(m_hash_index), int'(want_lookup.index));
                    if (m_bad_symbol !== want_lookup.bad)
                        report_mismatch("bad_symbol", int'(m_bad_symbol), int'(want_lookup.bad));
                end
            end
            m_ready <= $urandom_range(0, 99) >= recv_idle_pct;
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("perfect_hash_key_lookup_core verification failed");
            $finish;
        end
    end

    initial begin
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // reset settings: one-byte keys, g entry out of range ignored
        queue_load(ACT_VERTEX, 0, 16'hFFFF);
        queue_load(ACT_VERTEX, 13'h1FFF, 16'h5A5A);
        queue_byte(8'hFF);
        queue_byte(8'h00);
        settle();

        // byte below min, in set, past set size; then a clean key with a load inside it
        program_regs(3, 8'h41, 2, 4096, 32767);
        queue_byte(8'h40);
        queue_byte(8'h41);
        queue_byte(8'h43);
        queue_byte(8'h42);
        queue_load(ACT_FIRST, 13'h1FFF, 16'h0000);
        queue_byte(8'h41);
        queue_byte(8'h42);
        settle();

        for (int p = 0; p < RANDOM_PHASES; p++) begin
            case (p / 3)
                0: begin
                    send_idle_pct = 21;
                    recv_idle_pct = 76;
                end
                1: begin
                    send_idle_pct = 76;
                    recv_idle_pct = 21;
                end
                default: begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            case (p)
                0: program_regs(1, 0, 256, 4096, 32767);
                1: program_regs(63, 255, 511, 8191, 0);
                2: program_regs(0, 0, 0, 0, 0);
                3: program_regs(32, $urandom_range(0, 64), $urandom_range(64, 256), 4096, 1);
                4: program_regs(2, 0, 256, 4096, 32767);
                default: program_regs($urandom_range(1, 6), $urandom_range(0, 255),
                                      $urandom_range(0, 511), $urandom_range(0, 8191),
                                      $urandom_range(0, 32767));
            endcase
            phase_words = 0;
            while (phase_words < PHASE_BUDGET) queue_key();
            settle();
        end

        if (mismatch_count == 0) begin
            $display("perfect_hash_key_lookup_core verification clean");
        end else begin
            $display("perfect_hash_key_lookup_core verification failed");
        end
        $finish;
    end

endmodule
